### sv/rgb_thumbnail_difference_sum_core_macros.svh
// ----------------------------------------------------------------------------
// RGB thumbnail difference sum - assertion macros
// Concurrent assertion helpers for the checker file rtds_checker.
// ----------------------------------------------------------------------------
`ifndef RGB_THUMBNAIL_DIFFERENCE_SUM_CORE_MACROS_SVH
`define RGB_THUMBNAIL_DIFFERENCE_SUM_CORE_MACROS_SVH

// Property checked at each rising edge, ignored while reset is high.
`define RTDS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in %m");

// Property checked at each rising edge, reset included.
`define RTDS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed in %m");

`endif

### sv/rtds_pkg.sv
// ----------------------------------------------------------------------------
// rtds_pkg
// Constants, mode codes and helpers for the RGB thumbnail difference sum.
// ----------------------------------------------------------------------------
`default_nettype none

package rtds_pkg;

   localparam int PIXEL_COUNT_DEFAULT = 256;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 6 * CHAN_W;   // req tdata payload
   localparam int SUM_W   = 24;           // total_difference
   localparam int SCORE_W = 16;           // widest per-pixel score (luma)

   // Q8 luminance weights, 0.21 / 0.72 / 0.07, summing to 256
   localparam logic [CHAN_W-1:0] W_RED   = 8'd54;
   localparam logic [CHAN_W-1:0] W_GREEN = 8'd184;
   localparam logic [CHAN_W-1:0] W_BLUE  = 8'd18;

   localparam longint unsigned PIXEL_MAX_Q8 = 64'd65280;
   localparam longint unsigned FIELD24_MAX  = 64'hFF_FFFF;

   // compare_mode codes; the unused code falls back to plain
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_MONO  = 2'd1;
   localparam logic [1:0] MODE_LUMA  = 2'd2;

   function automatic logic [SUM_W-1:0] sum_limit(input int pixel_count);
      longint unsigned lim;
      lim = longint'(pixel_count) * PIXEL_MAX_Q8;
      if (lim > FIELD24_MAX) begin
         lim = FIELD24_MAX;
      end
      return lim[SUM_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

### sv/rgb_thumbnail_difference_sum_core.sv
// A last beat is held in s1, then its total is registered into the result slot on rsp.
// Throughput: one pixel beat per cycle but for the stall below; the single loop is
//   the saturating accumulator add.
// Input stalls only when a last beat meets a result still waiting on rsp.
// Reset (synchronous, high) clears mode, accumulator, clip flag and both valids.
// ----------------------------------------------------------------------------
// rgb_thumbnail_difference_sum_core
// Saturating sum of per-pixel RGB differences between two thumbnails, with
// plain SAD, luminance difference / 255 and weighted SAD modes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_thumbnail_difference_sum_core
   import rtds_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_wdata,    // compare_mode
   // pixel pair beats
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [7:0] search_red, [15:8] search_green, [23:16] search_blue,
   // [31:24] cand_red, [39:32] cand_green, [47:40] cand_blue
   input  wire logic [PIX_W-1:0]  req_tdata,
   input  wire logic              req_tlast,    // last_pixel
   // result beats
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [SUM_W-1:0]       rsp_tdata,    // [23:0] total_difference
   output logic                   rsp_tuser     // [0] saturated
);

   // Clip point of the accumulator, fixed at elaboration.
   localparam logic [SUM_W-1:0] SumLimit = sum_limit(PIXEL_COUNT);

   // ---------------- registers ----------------
   logic [1:0]        mode_ff, mode_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic              s1_last_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              clip_ff, clip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_data_ff;
   logic              rsp_sat_ff;

   // ---------------- handshake ----------------
   logic req_fire;
   logic acc_move;   // the held beat enters the accumulator this cycle

   // A non-last beat never needs the result slot, so only a last beat facing
   // an untaken result holds.
   assign acc_move   = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !s1_valid_ff || acc_move;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- per-pixel score ----------------
   logic [CHAN_W-1:0]  sr, sg, sb, cr, cg, cb;
   logic [CHAN_W-1:0]  dr, dg, db;
   logic [9:0]         plain_score;
   logic [SCORE_W-1:0] luma_score;
   logic [SCORE_W-1:0] lum_s, lum_c, lum_ad;
   logic [16:0]        mono_y, mono_t;
   logic [8:0]         mono_score;
   logic [SCORE_W-1:0] score;

   assign sr = s1_pix_ff[0*CHAN_W +: CHAN_W];
   assign sg = s1_pix_ff[1*CHAN_W +: CHAN_W];
   assign sb = s1_pix_ff[2*CHAN_W +: CHAN_W];
   assign cr = s1_pix_ff[3*CHAN_W +: CHAN_W];
   assign cg = s1_pix_ff[4*CHAN_W +: CHAN_W];
   assign cb = s1_pix_ff[5*CHAN_W +: CHAN_W];

   assign dr = abs_diff(sr, cr);
   assign dg = abs_diff(sg, cg);
   assign db = abs_diff(sb, cb);

   assign plain_score = 10'(dr) + 10'(dg) + 10'(db);

   // Weights sum to 256, so every Q8 sum here tops out at 65280.
   assign luma_score = 16'(dr) * 16'(W_RED) + 16'(dg) * 16'(W_GREEN)
                     + 16'(db) * 16'(W_BLUE);

   assign lum_s  = 16'(sr) * 16'(W_RED) + 16'(sg) * 16'(W_GREEN) + 16'(sb) * 16'(W_BLUE);
   assign lum_c  = 16'(cr) * 16'(W_RED) + 16'(cg) * 16'(W_GREEN) + 16'(cb) * 16'(W_BLUE);
   assign lum_ad = (lum_s >= lum_c) ? (lum_s - lum_c) : (lum_c - lum_s);

   // Round-half-up |L|/255: y = |L| + 127, then y/255 = (y + 1 + (y >> 8)) >> 8,
   // exact while the quotient stays at or below 256.
   assign mono_y     = 17'(lum_ad) + 17'd127;
   assign mono_t     = mono_y + 17'd1 + (mono_y >> 8);
   assign mono_score = mono_t[16:8];

   always_comb begin
      unique case (mode_ff)
         MODE_MONO: score = 16'(mono_score);
         MODE_LUMA: score = luma_score;
         default:   score = 16'(plain_score);
      endcase
   end

   // ---------------- saturating accumulate ----------------
   logic [SUM_W:0]   acc_raw;
   logic             acc_over;
   logic [SUM_W-1:0] acc_next;
   logic             clip_next;

   assign acc_raw   = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(score);
   assign acc_over  = acc_raw > (SUM_W+1)'(SumLimit);
   assign acc_next  = acc_over ? SumLimit : acc_raw[SUM_W-1:0];
   assign clip_next = clip_ff || acc_over;

   always_comb begin
      mode_in      = csr_we ? csr_wdata : mode_ff;

      s1_valid_in  = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (acc_move) begin
         s1_valid_in = 1'b0;
      end

      sum_in       = sum_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (acc_move) begin
         if (s1_last_ff) begin
            // frame done: hand off the total and start the next pair clean
            sum_in       = '0;
            clip_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            sum_in  = acc_next;
            clip_in = clip_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         sum_ff       <= sum_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (acc_move && s1_last_ff) begin
         rsp_data_ff <= acc_next;
         rsp_sat_ff  <= clip_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

`default_nettype wire

### sv/rtds_checker.sv
// ----------------------------------------------------------------------------
// rtds_checker
// Port-level checks on the RGB thumbnail difference sum core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_thumbnail_difference_sum_core_macros.svh"

module rtds_checker
   import rtds_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             req_tlast,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [SUM_W-1:0] rsp_tdata,
   input wire logic             rsp_tuser
);

   localparam logic [SUM_W-1:0] SumLimit = sum_limit(PIXEL_COUNT);

   // a stalled result beat holds
   `RTDS_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a fresh result on rsp follows an accepted last beat
   `RTDS_ASSERT(a_rsp_after_last, clock, reset,
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))

   // total never passes the clip point
   `RTDS_ASSERT(a_total_bounded, clock, reset,
      rsp_tvalid |-> rsp_tdata <= SumLimit)

   // reset empties the result slot
   `RTDS_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> !rsp_tvalid)

endmodule

bind rgb_thumbnail_difference_sum_core rtds_checker #(
   .PIXEL_COUNT (PIXEL_COUNT)
) u_rtds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
